[sv/lpht_pkg.sv]
package lpht_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int SLOT_W     = 9;
    localparam int SIZE_W     = 9;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    // key bits retired per cycle by the remainder unit
    localparam int MOD_DIGITS = 4;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_MORE   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } t_mod_req;

endpackage

[sv/linear_probe_hash_table.sv]
// Open-addressing hash table with linear probing over the first active_size slots.
// Input channel (i_in_valid / o_in_ready) carries one operation: insert, search
// by key, or next occupied slot at or after i_start_index. Each transaction gives
// exactly one result on the output channel (o_out_valid / i_out_ready).
// Config channel (i_cfg_valid / o_cfg_ready) writes active_size, always ready;
// the user must write it only while no operation is in flight (not enforced).
// Insert and search first pass through the modulo state (8 remainder steps of
// 4 key bits, then one step to hand over the home slot), then probe slot after
// slot, each probe a registered memory read and then a compare. Next scans
// slots from i_start_index with the same read and compare per slot. Refusals
// (full, start past the end, unknown opcode) skip the probing and go straight
// to the result. One operation is in flight at a time.
// The output register holds a finished result while the receiver stalls; the
// next transaction is accepted meanwhile, but its result waits until the
// register is free.
// Reset: occupancy flags live in memory and are cleared by a pass over all
// TABLE_DEPTH slots after reset, during which o_in_ready stays low. Entry count
// clears at once and active_size returns to 256. Keys and values are not cleared.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lpht_pkg::SIZE_W-1:0]        i_active_size,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lpht_pkg::OP_W-1:0]          i_opcode,
    input  logic [lpht_pkg::KEY_W-1:0]         i_lookup_key,
    input  logic [lpht_pkg::DATA_W-1:0]        i_entry_value,
    input  logic [lpht_pkg::SLOT_W-1:0]        i_start_index,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [lpht_pkg::STAT_W-1:0]        o_status,
    output logic [lpht_pkg::DATA_W-1:0]        o_found_value,
    output logic [lpht_pkg::KEY_W-1:0]         o_found_key,
    output logic [lpht_pkg::SLOT_W-1:0]        o_slot_index
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int S_W   = $clog2(TABLE_DEPTH + 1);

    // storage
    logic                           occ_mem [TABLE_DEPTH];
    logic [lpht_pkg::KEY_W-1:0]     key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0]          val_mem [TABLE_DEPTH];

    logic                           r_rd_occ;
    logic [lpht_pkg::KEY_W-1:0]     r_rd_key;
    logic [VALUE_BITS-1:0]          r_rd_val;

    // control
    lpht_pkg::t_state               r_state, n_state;
    logic [IDX_W-1:0]               r_ptr, n_ptr;
    logic [S_W-1:0]                 r_cnt, n_cnt;
    logic [S_W-1:0]                 r_count, n_count;
    logic [lpht_pkg::SIZE_W-1:0]    r_active_size;
    logic                           r_out_valid, n_out_valid;

    // operation in flight
    logic [lpht_pkg::OP_W-1:0]      r_op;
    logic [lpht_pkg::KEY_W-1:0]     r_key;
    logic [VALUE_BITS-1:0]          r_val;

    // pending result and output register
    logic [lpht_pkg::STAT_W-1:0]    r_res_status, n_res_status;
    logic [lpht_pkg::DATA_W-1:0]    r_res_value, n_res_value;
    logic [lpht_pkg::KEY_W-1:0]     r_res_key, n_res_key;
    logic [lpht_pkg::SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [lpht_pkg::STAT_W-1:0]    r_o_status, n_o_status;
    logic [lpht_pkg::DATA_W-1:0]    r_o_value, n_o_value;
    logic [lpht_pkg::KEY_W-1:0]     r_o_key, n_o_key;
    logic [lpht_pkg::SLOT_W-1:0]    r_o_slot, n_o_slot;

    logic [S_W-1:0]                 w_size;
    logic [S_W-1:0]                 w_ptr_inc;
    logic [IDX_W-1:0]               w_ptr_wrap;
    logic                           w_cnt_last;
    logic                           w_accept;
    logic                           w_occ_we;
    logic                           w_occ_wd;
    logic                           w_ent_we;
    lpht_pkg::t_mod_req             w_mod_req;
    logic                           w_mod_done;
    logic [S_W-1:0]                 w_mod_rem;

    lpht_mod #(
        .DIV_W (S_W)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mod_req),
        .i_divisor (w_size),
        .o_done    (w_mod_done),
        .o_rem     (w_mod_rem)
    );

    // effective size: zero acts as one, clamp to the table depth
    always_comb begin
        if (r_active_size == '0) begin
            w_size = S_W'(1);
        end else if (32'(r_active_size) > TABLE_DEPTH) begin
            w_size = S_W'(TABLE_DEPTH);
        end else begin
            w_size = S_W'(r_active_size);
        end
    end

    assign w_ptr_inc  = S_W'(r_ptr) + S_W'(1);
    assign w_ptr_wrap = (w_ptr_inc == w_size) ? '0 : IDX_W'(w_ptr_inc);
    assign w_cnt_last = (r_cnt + S_W'(1)) == w_size;
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == lpht_pkg::ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_found_value = r_o_value;
    assign o_found_key   = r_o_key;
    assign o_slot_index  = r_o_slot;

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_key    = r_res_key;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid;
        n_o_status   = r_o_status;
        n_o_value    = r_o_value;
        n_o_key      = r_o_key;
        n_o_slot     = r_o_slot;
        w_mod_req.start = 1'b0;
        w_mod_req.key   = i_lookup_key;
        w_occ_we     = 1'b0;
        w_occ_wd     = 1'b0;
        w_ent_we     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lpht_pkg::ST_CLEAR: begin
                w_occ_we = 1'b1;
                if (r_ptr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_ptr   = '0;
                    n_state = lpht_pkg::ST_IDLE;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            lpht_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_status = lpht_pkg::STAT_OK;
                    n_res_value  = '0;
                    n_res_key    = '0;
                    n_res_slot   = '0;
                    case (i_opcode)
                        lpht_pkg::OP_INSERT: begin
                            if (r_count >= w_size) begin
                                n_res_status = lpht_pkg::STAT_FULL;
                                n_state      = lpht_pkg::ST_DONE;
                            end else begin
                                w_mod_req.start = 1'b1;
                                n_state         = lpht_pkg::ST_MOD;
                            end
                        end
                        lpht_pkg::OP_SEARCH: begin
                            w_mod_req.start = 1'b1;
                            n_state         = lpht_pkg::ST_MOD;
                        end
                        lpht_pkg::OP_NEXT: begin
                            if (32'(i_start_index) >= 32'(w_size)) begin
                                n_res_status = lpht_pkg::STAT_NO_MORE;
                                n_res_slot   = lpht_pkg::SLOT_W'(w_size);
                                n_state      = lpht_pkg::ST_DONE;
                            end else begin
                                n_ptr   = IDX_W'(i_start_index);
                                n_state = lpht_pkg::ST_READ;
                            end
                        end
                        default: begin
                            n_res_status = lpht_pkg::STAT_NOT_FOUND;
                            n_state      = lpht_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lpht_pkg::ST_MOD: begin
                if (w_mod_done) begin
                    n_ptr   = IDX_W'(w_mod_rem);
                    n_cnt   = '0;
                    n_state = lpht_pkg::ST_READ;
                end
            end
            lpht_pkg::ST_READ: begin
                n_state = lpht_pkg::ST_CHECK;
            end
            lpht_pkg::ST_CHECK: begin
                case (r_op)
                    lpht_pkg::OP_INSERT: begin
                        if (!r_rd_occ) begin
                            w_occ_we     = 1'b1;
                            w_occ_wd     = 1'b1;
                            w_ent_we     = 1'b1;
                            n_count      = r_count + S_W'(1);
                            n_res_slot   = lpht_pkg::SLOT_W'(r_ptr);
                            n_state      = lpht_pkg::ST_DONE;
                        end else if (w_cnt_last) begin
                            n_res_status = lpht_pkg::STAT_FULL;
                            n_state      = lpht_pkg::ST_DONE;
                        end else begin
                            n_ptr   = w_ptr_wrap;
                            n_cnt   = r_cnt + S_W'(1);
                            n_state = lpht_pkg::ST_READ;
                        end
                    end
                    lpht_pkg::OP_SEARCH: begin
                        if (!r_rd_occ) begin
                            n_res_status = lpht_pkg::STAT_NOT_FOUND;
                            n_state      = lpht_pkg::ST_DONE;
                        end else if (r_rd_key == r_key) begin
                            n_res_value  = lpht_pkg::DATA_W'(r_rd_val);
                            n_res_slot   = lpht_pkg::SLOT_W'(r_ptr);
                            n_state      = lpht_pkg::ST_DONE;
                        end else if (w_cnt_last) begin
                            n_res_status = lpht_pkg::STAT_NOT_FOUND;
                            n_state      = lpht_pkg::ST_DONE;
                        end else begin
                            n_ptr   = w_ptr_wrap;
                            n_cnt   = r_cnt + S_W'(1);
                            n_state = lpht_pkg::ST_READ;
                        end
                    end
                    lpht_pkg::OP_NEXT: begin
                        if (r_rd_occ) begin
                            n_res_key  = r_rd_key;
                            n_res_slot = lpht_pkg::SLOT_W'(r_ptr);
                            n_state    = lpht_pkg::ST_DONE;
                        end else if (w_ptr_inc == w_size) begin
                            n_res_status = lpht_pkg::STAT_NO_MORE;
                            n_res_slot   = lpht_pkg::SLOT_W'(w_size);
                            n_state      = lpht_pkg::ST_DONE;
                        end else begin
                            n_ptr   = IDX_W'(w_ptr_inc);
                            n_state = lpht_pkg::ST_READ;
                        end
                    end
                    default: begin
                        n_res_status = lpht_pkg::STAT_NOT_FOUND;
                        n_state      = lpht_pkg::ST_DONE;
                    end
                endcase
            end
            lpht_pkg::ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_value   = r_res_value;
                    n_o_key     = r_res_key;
                    n_o_slot    = r_res_slot;
                    n_state     = lpht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lpht_pkg::ST_CLEAR;
            r_ptr         <= '0;
            r_cnt         <= '0;
            r_count       <= '0;
            r_active_size <= lpht_pkg::SIZE_W'(256);
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_size <= i_active_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_key    <= n_res_key;
        r_res_slot   <= n_res_slot;
        r_o_status   <= n_o_status;
        r_o_value    <= n_o_value;
        r_o_key      <= n_o_key;
        r_o_slot     <= n_o_slot;
        if (w_accept) begin
            r_op  <= i_opcode;
            r_key <= i_lookup_key;
            r_val <= VALUE_BITS'(i_entry_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_occ_we) begin
            occ_mem[r_ptr] <= w_occ_wd;
        end
        r_rd_occ <= occ_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            key_mem[r_ptr] <= r_key;
            val_mem[r_ptr] <= r_val;
        end
        r_rd_key <= key_mem[r_ptr];
        r_rd_val <= val_mem[r_ptr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= S_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("accepted a second transaction while busy");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ent_we |=> r_count == $past(r_count) + S_W'(1))
        else $error("insert did not advance entry count");

    a_mod_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> r_state == lpht_pkg::ST_MOD)
        else $error("remainder finished outside modulo state");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == lpht_pkg::ST_DONE)
        else $error("result raised without a finished operation");

endmodule

[sv/lpht_mod.sv]
module lpht_mod #(
    parameter int DIV_W = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpht_pkg::t_mod_req  i_req,
    input  logic [DIV_W-1:0]    i_divisor,
    output logic                o_done,
    output logic [DIV_W-1:0]    o_rem
);

    localparam int STEPS = lpht_pkg::KEY_W / lpht_pkg::MOD_DIGITS;
    localparam int CNT_W = $clog2(STEPS);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [DIV_W-1:0]          r_rem;
    logic [lpht_pkg::KEY_W-1:0] r_key;

    logic [DIV_W:0]            w_t;
    logic [DIV_W-1:0]          w_rem;

    // restoring remainder, several key bits per cycle, MSB first
    always_comb begin
        w_rem = r_rem;
        w_t   = '0;
        for (int k = 0; k < lpht_pkg::MOD_DIGITS; k++) begin
            w_t = {w_rem, r_key[lpht_pkg::KEY_W-1-k]};
            if (w_t >= {1'b0, i_divisor}) begin
                w_t = w_t - {1'b0, i_divisor};
            end
            w_rem = w_t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_W'(STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_key <= i_req.key;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_key <= r_key << lpht_pkg::MOD_DIGITS;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
